FILE: hdl/affine_matrix_vertex_transform_assert.svh
// assertion macros shared by the checker
`ifndef AFFINE_MATRIX_VERTEX_TRANSFORM_ASSERT_SVH
`define AFFINE_MATRIX_VERTEX_TRANSFORM_ASSERT_SVH
// same-cycle implication, off during reset
`define AMVT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amvt check failed");
// next-cycle implication, off during reset
`define AMVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amvt check failed");
// what reset must leave behind
`define AMVT_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("amvt reset check failed");
`endif

FILE: hdl/amvt_pkg.sv
package amvt_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_ELEM    = 12;
  localparam int ELEM_W      = 4;
  localparam int NUM_LANES   = 3;
  localparam int PROD_W      = 2 * VALUE_WIDTH - FRAC_BITS;
  localparam int SUM_W       = PROD_W + 3;

  typedef logic signed [VALUE_WIDTH-1:0]   val_t;
  typedef logic signed [2*VALUE_WIDTH-1:0] full_t;
  typedef logic signed [PROD_W-1:0]        prod_t;
  typedef logic signed [SUM_W-1:0]         sum_t;
  typedef logic [ELEM_W-1:0]               elem_t;

  typedef enum logic [3:0] {
    REQ_VERTEX   = 4'd0,
    REQ_IDENTITY = 4'd1,
    REQ_SCALE    = 4'd2,
    REQ_AXIS     = 4'd3,
    REQ_TRANS    = 4'd4,
    REQ_ROTX     = 4'd5,
    REQ_ROTY     = 4'd6,
    REQ_ROTZ     = 4'd7,
    REQ_LOAD     = 4'd8,
    REQ_MULT     = 4'd9
  } req_t;

  // three products (optionally negated) plus two addends
  typedef struct packed {
    val_t [2:0] a;
    val_t [2:0] b;
    logic [2:0] neg;
    val_t       add0;
    val_t       add1;
  } lane_op_t;

  localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam val_t ONE = (FRAC_BITS < VALUE_WIDTH - 1) ?
                         val_t'(64'd1 << FRAC_BITS) : VAL_MAX;

  function automatic val_t sat(input sum_t s);
    if (s > sum_t'(VAL_MAX)) return VAL_MAX;
    if (s < sum_t'(VAL_MIN)) return VAL_MIN;
    return val_t'(s);
  endfunction
endpackage

FILE: hdl/amvt_in_if.sv
interface amvt_in_if import amvt_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [3:0]  elem_index;
  val_t        val_a;
  val_t        val_b;
  val_t        val_c;
  logic        last_vertex;

  modport source (output valid, req_type, elem_index, val_a, val_b, val_c, last_vertex,
                  input ready);
  modport sink (input valid, req_type, elem_index, val_a, val_b, val_c, last_vertex,
                output ready);
endinterface

FILE: hdl/amvt_out_if.sv
interface amvt_out_if import amvt_pkg::*; ();
  logic valid;
  logic ready;
  val_t out_x;
  val_t out_y;
  val_t out_z;
  logic out_last;

  modport source (output valid, out_x, out_y, out_z, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

FILE: hdl/amvt_lane.sv
module amvt_lane import amvt_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  lane_op_t op,
  output val_t     result
);
  prod_t                    prod [3];
  logic [2:0]               neg;
  logic signed [VALUE_WIDTH:0] add;
  sum_t                     sum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod[k] <= prod_t'((full_t'($signed(op.a[k])) * full_t'($signed(op.b[k])))
                           >>> FRAC_BITS);
      end
      neg <= op.neg;
      add <= $signed({op.add0[VALUE_WIDTH-1], op.add0})
           + $signed({op.add1[VALUE_WIDTH-1], op.add1});
    end
  end

  always_comb begin
    sum = sum_t'(add);
    for (int k = 0; k < 3; k++) begin
      if (neg[k]) sum = sum - sum_t'(prod[k]);
      else        sum = sum + sum_t'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) result <= sat(sum);
  end
endmodule

FILE: hdl/amvt_merge.sv
module amvt_merge import amvt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  issue,
  input  logic  last,
  input  val_t  lane_res [NUM_LANES],
  output logic  adv,
  output logic  pipe_empty,
  amvt_out_if.source item_out
);
  logic v1;
  logic last1;
  logic ovalid;
  logic olast;

  assign adv        = !ovalid || item_out.ready;
  assign pipe_empty = !v1 && !ovalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      ovalid <= 1'b0;
    end else if (adv) begin
      v1     <= issue;
      ovalid <= v1;
    end
    if (adv) begin
      last1 <= last;
      olast <= last1;
    end
  end

  assign item_out.valid    = ovalid;
  assign item_out.out_x    = lane_res[0];
  assign item_out.out_y    = lane_res[1];
  assign item_out.out_z    = lane_res[2];
  assign item_out.out_last = olast;
endmodule

FILE: hdl/amvt_seq.sv
module amvt_seq import amvt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [3:0] req_type,
  input  logic [3:0] elem_index,
  input  val_t       val_a,
  input  val_t       val_b,
  input  val_t       val_c,
  input  logic       pipe_empty,
  input  val_t       lane0_res,
  output logic       busy,
  output logic       run,
  output lane_op_t   op,
  output val_t       cur [NUM_ELEM]
);
  typedef enum logic [1:0] {IDLE, DRAIN, RUN} state_t;

  state_t     state;
  logic [3:0] op_q;
  val_t       va, vb, vc;
  val_t       rhs [NUM_ELEM];
  val_t       nm  [NUM_ELEM];
  elem_t      cnt;
  logic       m1_v, m2_v;
  elem_t      m1_e, m2_e;

  elem_t      e;
  logic [1:0] row, col, p, q;
  val_t       vrow;

  assign busy = (state != IDLE);
  assign run  = (state == RUN) && (cnt < elem_t'(NUM_ELEM));

  always_comb begin
    e    = run ? cnt : '0;
    row  = e[3:2];
    col  = e[1:0];
    vrow = (row == 2'd0) ? va : (row == 2'd1) ? vb : vc;
    case (op_q)
      REQ_ROTX: begin p = 2'd1; q = 2'd2; end
      REQ_ROTY: begin p = 2'd0; q = 2'd2; end
      REQ_ROTZ: begin p = 2'd1; q = 2'd0; end
      default:  begin p = 2'd3; q = 2'd3; end
    endcase
    op      = '0;
    op.add0 = cur[e];
    case (op_q)
      REQ_SCALE: begin
        op.a[0] = cur[e]; op.b[0] = va; op.add0 = '0;
      end
      REQ_AXIS: begin
        op.a[0] = cur[e]; op.b[0] = vrow; op.add0 = '0;
      end
      REQ_TRANS: begin
        if (col == 2'd3) op.add1 = vrow;
      end
      REQ_ROTX, REQ_ROTY, REQ_ROTZ: begin
        if (row == p) begin
          op.a[0] = cur[{p, col}]; op.b[0] = va;
          op.a[1] = cur[{q, col}]; op.b[1] = vb;
          op.add0 = '0;
        end else if (row == q) begin
          op.a[0] = cur[{q, col}]; op.b[0] = va;
          op.a[1] = cur[{p, col}]; op.b[1] = vb; op.neg[1] = 1'b1;
          op.add0 = '0;
        end
      end
      REQ_MULT: begin
        for (int k = 0; k < 3; k++) begin
          op.a[k] = rhs[{row, 2'(k)}];
          op.b[k] = cur[{2'(k), col}];
        end
        op.add0 = (col == 2'd3) ? rhs[{row, 2'd3}] : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
      m1_v  <= 1'b0;
      m2_v  <= 1'b0;
      for (int i = 0; i < NUM_ELEM; i++) begin
        cur[i] <= (i % 5 == 0) ? ONE : '0;
      end
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_IDENTITY: begin
                for (int i = 0; i < NUM_ELEM; i++) begin
                  cur[i] <= (i % 5 == 0) ? ONE : '0;
                end
              end
              REQ_LOAD: begin
                if (elem_index < elem_t'(NUM_ELEM)) rhs[elem_index] <= val_a;
              end
              REQ_SCALE, REQ_AXIS, REQ_TRANS, REQ_ROTX, REQ_ROTY, REQ_ROTZ,
              REQ_MULT: begin
                op_q  <= req_type;
                va    <= val_a;
                vb    <= val_b;
                vc    <= val_c;
                state <= DRAIN;
              end
              default: begin
              end
            endcase
          end
        end
        DRAIN: begin
          // let vertices already in flight leave with the old matrix
          if (pipe_empty) begin
            state <= RUN;
            cnt   <= '0;
          end
        end
        RUN: begin
          m1_v <= run;
          m1_e <= cnt;
          m2_v <= m1_v;
          m2_e <= m1_e;
          if (run) cnt <= cnt + 1'b1;
          if (m2_v) nm[m2_e] <= lane0_res;
          // the sweep has already run dry here, so m1_v and m2_v fall by themselves
          if (m2_v && m2_e == elem_t'(NUM_ELEM - 1)) begin
            for (int i = 0; i < NUM_ELEM - 1; i++) cur[i] <= nm[i];
            cur[NUM_ELEM-1] <= lane0_res;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/affine_matrix_vertex_transform.sv
// vertex items: lane, then result register; one item per cycle while out ready
// each of three lanes does one row: three 32x32 products, then sum and saturate
// matrix updates (scale, translate, rotate, multiply) stall input: wait for the
// pipeline to drain, then sweep 12 elements through lane 0
// identity and rhs element loads complete in the accept cycle
// synchronous reset sets the matrix to identity and empties the pipeline
module affine_matrix_vertex_transform import amvt_pkg::*; (
  input logic        clk,
  input logic        rst,
  amvt_in_if.sink    item_in,
  amvt_out_if.source item_out
);
  logic     adv;
  logic     pipe_empty;
  logic     busy;
  logic     run;
  logic     accept;
  logic     issue;
  lane_op_t seq_op;
  lane_op_t lane_op [NUM_LANES];
  val_t     cur [NUM_ELEM];
  val_t     lane_res [NUM_LANES];

  assign item_in.ready = adv && !busy;
  assign accept        = item_in.valid && item_in.ready;
  assign issue         = accept && (item_in.req_type == REQ_VERTEX);

  amvt_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (item_in.req_type),
    .elem_index (item_in.elem_index),
    .val_a      (item_in.val_a),
    .val_b      (item_in.val_b),
    .val_c      (item_in.val_c),
    .pipe_empty (pipe_empty),
    .lane0_res  (lane_res[0]),
    .busy       (busy),
    .run        (run),
    .op         (seq_op),
    .cur        (cur)
  );

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_op[l].a    = {item_in.val_c, item_in.val_b, item_in.val_a};
      lane_op[l].neg  = '0;
      lane_op[l].add1 = '0;
      lane_op[l].add0 = cur[elem_t'(l * 4 + 3)];
      for (int k = 0; k < 3; k++) begin
        lane_op[l].b[k] = cur[elem_t'(l * 4 + k)];
      end
    end
    // lane 0 doubles as the matrix update unit
    if (run) lane_op[0] = seq_op;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    amvt_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .op     (lane_op[l]),
      .result (lane_res[l])
    );
  end

  amvt_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .last       (item_in.last_vertex),
    .lane_res   (lane_res),
    .adv        (adv),
    .pipe_empty (pipe_empty),
    .item_out   (item_out)
  );
endmodule

FILE: hdl/amvt_checker.sv
`include "affine_matrix_vertex_transform_assert.svh"

module amvt_props import amvt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [3:0] in_req,
  input logic       out_valid,
  input logic       out_ready,
  input val_t       out_x
);
  `AMVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x))
  `AMVT_ASSERT_RESET(a_rst_empty, !out_valid)
  `AMVT_ASSERT_NEXT(a_vertex_lat, (in_valid && in_ready && in_req == REQ_VERTEX) ##1 out_ready, out_valid)
  `AMVT_ASSERT_NEXT(a_update_stalls, in_valid && in_ready && (in_req == REQ_SCALE || in_req == REQ_AXIS || in_req == REQ_TRANS || in_req == REQ_ROTX || in_req == REQ_ROTY || in_req == REQ_ROTZ || in_req == REQ_MULT), !in_ready)
endmodule

bind affine_matrix_vertex_transform amvt_props u_amvt_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item_in.valid),
  .in_ready  (item_in.ready),
  .in_req    (item_in.req_type),
  .out_valid (item_out.valid),
  .out_ready (item_out.ready),
  .out_x     (item_out.out_x)
);
